// ===== src/kcm_pkg.sv =====
// Shared types and constants of the keyboard cursor motion block.
// Holds the item payloads, the register file layout and the work record.
// Depends on nothing; every other file of the block but kcm_stream_if imports it.
package kcm_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_SET     = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    // Event kinds of a result item.
    localparam logic [1:0] EVT_ACT_PRESS   = 2'd0;
    localparam logic [1:0] EVT_ACT_RELEASE = 2'd1;
    localparam logic [1:0] EVT_MOVE        = 2'd2;

    // Action codes.
    localparam logic [1:0] ACT_A = 2'd0;
    localparam logic [1:0] ACT_B = 2'd1;
    localparam logic [1:0] ACT_C = 2'd2;

    // Bits of the mode register.
    localparam int unsigned MODE_ACTIVE = 0;
    localparam int unsigned MODE_KBD    = 1;
    localparam int unsigned MODE_PTR    = 2;
    localparam int unsigned MODE_SEL    = 3;

    // Byte positions of the key codes within the key map.
    localparam int unsigned KEY_LEFT  = 0;
    localparam int unsigned KEY_RIGHT = 1;
    localparam int unsigned KEY_UP    = 2;
    localparam int unsigned KEY_DOWN  = 3;
    localparam int unsigned KEY_ACT_A = 4;
    localparam int unsigned KEY_ACT_C = 5;
    localparam int unsigned KEY_ACT_B = 6;

    // Configuration port layout.
    localparam int unsigned CFG_ADDR_W = 6;
    localparam int unsigned CFG_DATA_W = 64;
    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_MAX_SPEED = 3'd1;
    localparam logic [2:0] REG_SPEED_CAP = 3'd2;
    localparam logic [2:0] REG_KEY_MAP   = 3'd3;
    localparam logic [2:0] REG_BOUNDS    = 3'd4;

    localparam logic [15:0] MAX_SPEED_RST = 16'h0199;
    localparam logic [30:0] SPEED_CAP_RST = 31'h0000_8000;
    localparam logic [55:0] KEY_MAP_RST   = 56'd20547806477485059;

    typedef struct packed {
        logic [1:0]        operation;
        logic [7:0]        key_code;
        logic [31:0]       time_ms;
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
        logic [2:0]        source_state;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        event_kind;
        logic [1:0]        action;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]       event_time;
    } t_out_item;

    typedef struct packed {
        logic [3:0]  mode_flags;
        logic [15:0] max_speed;
        logic [30:0] speed_cap;
        logic [55:0] key_map;
        logic [63:0] bounds;
    } t_cfg;

    // Direction of one axis: sign, magnitude, and the magnitude split as 20*quo + rem.
    typedef struct packed {
        logic        neg;
        logic [15:0] mag;
        logic [11:0] mag_quo;
        logic [4:0]  mag_rem;
    } t_dir;

    // Velocity growth request of one axis; elapsed time split as 20*quo + rem.
    typedef struct packed {
        logic        en;
        t_dir        dir;
        logic [27:0] el_quo;
        logic [4:0]  el_rem;
    } t_grow;

    typedef enum logic [2:0] {
        WK_NONE,
        WK_SET,
        WK_ACTION,
        WK_RELEASE,
        WK_TICK
    } t_work_kind;

    // What the core has to do for one accepted item.
    typedef struct packed {
        t_work_kind        kind;
        logic [1:0]        evt_kind;
        logic [1:0]        action;
        logic [31:0]       event_time;
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
        logic              clr_x;
        logic              clr_y;
        logic              report;
        t_grow             grow_x;
        t_grow             grow_y;
    } t_work;

endpackage

// ===== src/kcm_stream_if.sv =====
// Valid/ready stream channel used for the input and result items.
// The payload type is chosen where the channel is instantiated.
// Depends on nothing.
interface kcm_stream_if #(
    parameter type T_DATA = logic
);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/kcm_cfg.sv =====
// Register file behind the APB-style configuration port.
// Depends on kcm_pkg for the register layout and reset values.
module kcm_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kcm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [kcm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [kcm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output kcm_pkg::t_cfg                  o_cfg
);
    import kcm_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode_flags <= '0;
            r_cfg.max_speed  <= MAX_SPEED_RST;
            r_cfg.speed_cap  <= SPEED_CAP_RST;
            r_cfg.key_map    <= KEY_MAP_RST;
            r_cfg.bounds     <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MODE:      r_cfg.mode_flags <= pwdata[3:0];
                REG_MAX_SPEED: r_cfg.max_speed  <= pwdata[15:0];
                REG_SPEED_CAP: r_cfg.speed_cap  <= pwdata[30:0];
                REG_KEY_MAP:   r_cfg.key_map    <= pwdata[55:0];
                REG_BOUNDS:    r_cfg.bounds     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE:      prdata = CFG_DATA_W'(r_cfg.mode_flags);
            REG_MAX_SPEED: prdata = CFG_DATA_W'(r_cfg.max_speed);
            REG_SPEED_CAP: prdata = CFG_DATA_W'(r_cfg.speed_cap);
            REG_KEY_MAP:   prdata = CFG_DATA_W'(r_cfg.key_map);
            REG_BOUNDS:    prdata = r_cfg.bounds;
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== src/kcm_front.sv =====
// Input stage: decodes each item, keeps per-axis direction and time stamp,
// splits elapsed time by twenty and loads the work record into the input register.
// Depends on kcm_pkg and kcm_stream_if.
module kcm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  kcm_pkg::t_cfg  i_cfg,
    kcm_stream_if.sink     i_in,
    input  logic           i_advance,
    output logic           o_valid,
    output kcm_pkg::t_work o_work
);
    import kcm_pkg::*;

    localparam logic [31:0] RECIP5_32 = 32'hCCCC_CCCD;
    localparam logic [15:0] RECIP5_16 = 16'hCCCD;

    // Quotient and remainder by twenty of a 32-bit value: (e/4)/5 by reciprocal.
    function automatic logic [32:0] f_div20_32(input logic [31:0] e);
        logic [63:0] prod;
        logic [27:0] quo;
        logic [31:0] quo20;
        prod  = 64'(e >> 2) * 64'(RECIP5_32);
        quo   = prod[61:34];
        quo20 = 32'({quo, 4'b0000}) + 32'({quo, 2'b00});
        return {quo, 5'(e - quo20)};
    endfunction

    // Direction record for a press of the given sign at the given magnitude.
    function automatic t_dir f_make_dir(input logic neg, input logic [15:0] mag);
        t_dir        d;
        logic [31:0] prod;
        logic [15:0] quo20;
        prod      = 32'(mag >> 2) * 32'(RECIP5_16);
        d.neg     = neg;
        d.mag     = mag;
        d.mag_quo = prod[29:18];
        quo20     = 16'({d.mag_quo, 4'b0000}) + 16'({d.mag_quo, 2'b00});
        d.mag_rem = 5'(mag - quo20);
        return d;
    endfunction

    t_dir        r_dir_x, r_dir_y, n_dir_x, n_dir_y;
    logic [31:0] r_stamp_x, r_stamp_y, n_stamp_x, n_stamp_y;
    logic        r_valid;
    t_work       r_work, n_work;

    logic        accept;
    logic        active, kbd, ptr, sel, gate;
    logic [7:0]  code;
    logic [31:0] now;
    logic        hit_left, hit_right, hit_up, hit_down, hit_a, hit_b, hit_c;
    logic [32:0] split_x, split_y;

    assign i_in.ready = !r_valid || i_advance;
    assign accept     = i_in.valid && i_in.ready;
    assign o_valid    = r_valid;
    assign o_work     = r_work;

    assign active = i_cfg.mode_flags[MODE_ACTIVE];
    assign kbd    = i_cfg.mode_flags[MODE_KBD];
    assign ptr    = i_cfg.mode_flags[MODE_PTR];
    assign sel    = i_cfg.mode_flags[MODE_SEL];
    assign code   = i_in.data.key_code;
    assign now    = i_in.data.time_ms;
    assign gate   = (ptr && i_in.data.source_state[0])
                 || (kbd && (i_in.data.source_state[2:1] != 2'b00));

    assign hit_left  = i_cfg.key_map[KEY_LEFT*8 +: 8] == code;
    assign hit_right = i_cfg.key_map[KEY_RIGHT*8 +: 8] == code;
    assign hit_up    = i_cfg.key_map[KEY_UP*8 +: 8] == code;
    assign hit_down  = i_cfg.key_map[KEY_DOWN*8 +: 8] == code;
    assign hit_a     = i_cfg.key_map[KEY_ACT_A*8 +: 8] == code;
    assign hit_b     = i_cfg.key_map[KEY_ACT_B*8 +: 8] == code;
    assign hit_c     = i_cfg.key_map[KEY_ACT_C*8 +: 8] == code;

    assign split_x = f_div20_32(now - r_stamp_x);
    assign split_y = f_div20_32(now - r_stamp_y);

    always_comb begin
        n_dir_x   = r_dir_x;
        n_dir_y   = r_dir_y;
        n_stamp_x = r_stamp_x;
        n_stamp_y = r_stamp_y;

        n_work            = '0;
        n_work.kind       = WK_NONE;
        n_work.event_time = now;
        n_work.new_x      = i_in.data.new_x;
        n_work.new_y      = i_in.data.new_y;
        n_work.report     = kbd;

        if (active) begin
            case (i_in.data.operation)
                OP_SET: begin
                    if (ptr) begin
                        n_work.kind = WK_SET;
                    end
                end
                OP_PRESS, OP_RELEASE: begin
                    if (kbd) begin
                        if (sel && (hit_a || hit_b || hit_c)) begin
                            n_work.kind     = WK_ACTION;
                            n_work.evt_kind = (i_in.data.operation == OP_PRESS)
                                            ? EVT_ACT_PRESS : EVT_ACT_RELEASE;
                            n_work.action   = hit_a ? ACT_A : (hit_b ? ACT_B : ACT_C);
                        end else if (i_in.data.operation == OP_RELEASE) begin
                            n_work.kind = WK_RELEASE;
                            if (hit_up || hit_down) begin
                                n_work.clr_y = 1'b1;
                                n_dir_y      = '0;
                            end else if (hit_left || hit_right) begin
                                n_work.clr_x = 1'b1;
                                n_dir_x      = '0;
                            end
                        end else if (hit_up) begin
                            n_stamp_y = now;
                            n_dir_y   = f_make_dir(1'b1, i_cfg.max_speed);
                        end else if (hit_down) begin
                            n_stamp_y = now;
                            n_dir_y   = f_make_dir(1'b0, i_cfg.max_speed);
                        end else if (hit_left) begin
                            n_stamp_x = now;
                            n_dir_x   = f_make_dir(1'b1, i_cfg.max_speed);
                        end else if (hit_right) begin
                            n_stamp_x = now;
                            n_dir_x   = f_make_dir(1'b0, i_cfg.max_speed);
                        end
                    end
                end
                OP_TICK: begin
                    if (gate) begin
                        n_work.kind = WK_TICK;
                        if (r_dir_x.mag != '0) begin
                            n_work.grow_x.en     = 1'b1;
                            n_work.grow_x.dir    = r_dir_x;
                            n_work.grow_x.el_quo = split_x[32:5];
                            n_work.grow_x.el_rem = split_x[4:0];
                            n_stamp_x            = now;
                        end
                        if (r_dir_y.mag != '0) begin
                            n_work.grow_y.en     = 1'b1;
                            n_work.grow_y.dir    = r_dir_y;
                            n_work.grow_y.el_quo = split_y[32:5];
                            n_work.grow_y.el_rem = split_y[4:0];
                            n_stamp_y            = now;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_dir_x   <= '0;
            r_dir_y   <= '0;
            r_stamp_x <= '0;
            r_stamp_y <= '0;
        end else begin
            if (accept) begin
                r_valid   <= 1'b1;
                r_dir_x   <= n_dir_x;
                r_dir_y   <= n_dir_y;
                r_stamp_x <= n_stamp_x;
                r_stamp_y <= n_stamp_y;
            end else if (i_advance) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_work <= n_work;
        end
    end

endmodule

// ===== src/kcm_core.sv =====
// Motion stage: velocity growth with saturation, fixed-point position update,
// move report and bounds clamping, ending in the result register.
// Depends on kcm_pkg and kcm_stream_if.
module kcm_core #(
    parameter int FRAC_BITS = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  kcm_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  kcm_pkg::t_work i_work,
    output logic           o_advance,
    kcm_stream_if.source   o_out
);
    import kcm_pkg::*;

    localparam int unsigned MAX_SMALL_QUO = 18;

    // New velocity: vel + sign * floor(mag * elapsed / 20), saturated at +-cap.
    // mag*elapsed/20 = mag*qe + mq*re + floor(mr*re/20) with mag = 20*mq + mr.
    function automatic logic signed [31:0] f_grow(input logic signed [31:0] vel,
                                                  input t_grow g,
                                                  input logic [30:0] cap);
        logic [43:0]        p_main;
        logic [16:0]        p_mid;
        logic [8:0]         p_low;
        logic [MAX_SMALL_QUO:1] ge;
        logic [4:0]         low_quo;
        logic [44:0]        mag;
        logic signed [46:0] delta;
        logic signed [46:0] sum;
        logic signed [46:0] cap_s;
        p_main = 44'(g.dir.mag) * 44'(g.el_quo);
        p_mid  = 17'(g.dir.mag_quo) * 17'(g.el_rem);
        p_low  = 9'(g.dir.mag_rem) * 9'(g.el_rem);
        for (int k = 1; k <= MAX_SMALL_QUO; k++) begin
            ge[k] = p_low >= 9'(20 * k);
        end
        low_quo = 5'($countones(ge));
        mag   = 45'(p_main) + 45'(p_mid) + 45'(low_quo);
        delta = g.dir.neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        sum   = 47'(vel) + delta;
        cap_s = $signed(47'(cap));
        if (sum > cap_s) begin
            sum = cap_s;
        end else if (sum < -cap_s) begin
            sum = -cap_s;
        end
        return sum[31:0];
    endfunction

    logic [31:0]        r_fixed_x, r_fixed_y, n_fixed_x, n_fixed_y;
    logic signed [15:0] r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic signed [31:0] r_vel_x, r_vel_y, n_vel_x, n_vel_y;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               take;
    logic signed [31:0] vel_x_t, vel_y_t;
    logic [31:0]        fix_x_t, fix_y_t;
    logic signed [15:0] pos_x_t, pos_y_t, clamp_x, clamp_y;
    logic signed [15:0] bx, by, bw, bh, right, bottom, r1, b1;
    logic               moved, outside, clamp_on;

    assign o_advance   = !r_out_valid || o_out.ready;
    assign take        = i_valid && o_advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Tick datapath, evaluated every cycle and used only for a tick.
    assign vel_x_t = i_work.grow_x.en ? f_grow(r_vel_x, i_work.grow_x, i_cfg.speed_cap)
                                      : r_vel_x;
    assign vel_y_t = i_work.grow_y.en ? f_grow(r_vel_y, i_work.grow_y, i_cfg.speed_cap)
                                      : r_vel_y;
    assign fix_x_t = r_fixed_x + vel_x_t;
    assign fix_y_t = r_fixed_y + vel_y_t;
    assign pos_x_t = fix_x_t[FRAC_BITS +: 16];
    assign pos_y_t = fix_y_t[FRAC_BITS +: 16];
    assign moved   = i_work.report && ((pos_x_t != r_pos_x) || (pos_y_t != r_pos_y));

    assign bx     = i_cfg.bounds[15:0];
    assign by     = i_cfg.bounds[31:16];
    assign bw     = i_cfg.bounds[47:32];
    assign bh     = i_cfg.bounds[63:48];
    assign right  = bx + bw;
    assign bottom = by + bh;
    assign r1     = right - 16'sd1;
    assign b1     = bottom - 16'sd1;
    assign outside = (bx > pos_x_t) || (right <= pos_x_t)
                  || (by > pos_y_t) || (bottom <= pos_y_t);
    assign clamp_on = (bw != '0) && (bh != '0) && outside;

    always_comb begin
        clamp_x = (pos_x_t < bx) ? bx : pos_x_t;
        clamp_x = (clamp_x > r1) ? r1 : clamp_x;
        clamp_y = (pos_y_t < by) ? by : pos_y_t;
        clamp_y = (clamp_y > b1) ? b1 : clamp_y;
    end

    always_comb begin
        n_fixed_x   = r_fixed_x;
        n_fixed_y   = r_fixed_y;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_vel_x     = r_vel_x;
        n_vel_y     = r_vel_y;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;

        if (take) begin
            case (i_work.kind)
                WK_SET: begin
                    n_pos_x   = i_work.new_x;
                    n_pos_y   = i_work.new_y;
                    n_fixed_x = 32'(i_work.new_x) << FRAC_BITS;
                    n_fixed_y = 32'(i_work.new_y) << FRAC_BITS;
                end
                WK_ACTION: begin
                    n_out_valid      = 1'b1;
                    n_out.event_kind = i_work.evt_kind;
                    n_out.action     = i_work.action;
                    n_out.pos_x      = r_pos_x;
                    n_out.pos_y      = r_pos_y;
                    n_out.event_time = i_work.event_time;
                end
                WK_RELEASE: begin
                    if (i_work.clr_x) begin
                        n_vel_x = '0;
                    end
                    if (i_work.clr_y) begin
                        n_vel_y = '0;
                    end
                end
                WK_TICK: begin
                    n_vel_x = vel_x_t;
                    n_vel_y = vel_y_t;
                    if (moved) begin
                        n_out_valid      = 1'b1;
                        n_out.event_kind = EVT_MOVE;
                        n_out.action     = ACT_A;
                        n_out.pos_x      = pos_x_t;
                        n_out.pos_y      = pos_y_t;
                        n_out.event_time = i_work.event_time;
                    end
                    if (clamp_on) begin
                        n_pos_x   = clamp_x;
                        n_pos_y   = clamp_y;
                        n_fixed_x = 32'(clamp_x) << FRAC_BITS;
                        n_fixed_y = 32'(clamp_y) << FRAC_BITS;
                    end else begin
                        n_pos_x   = pos_x_t;
                        n_pos_y   = pos_y_t;
                        n_fixed_x = fix_x_t;
                        n_fixed_y = fix_y_t;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fixed_x   <= '0;
            r_fixed_y   <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_fixed_x   <= n_fixed_x;
            r_fixed_y   <= n_fixed_y;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_vel_x     <= n_vel_x;
            r_vel_y     <= n_vel_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// ===== src/keyboard_cursor_motion.sv =====
// Keyboard-driven pointer with acceleration, top level.
// Instantiates the register file, the input stage and the motion stage.
// Depends on kcm_pkg, kcm_stream_if, kcm_cfg, kcm_front and kcm_core.
//
// Use: input items (key press, key release, pointer set, tick) arrive as
// transfers on the i_in channel; result items (action pressed, action
// released, position moved) leave as transfers on the o_out channel. An item
// produces at most one result. Registers are written through the APB-style
// port; the user must write them only while the block is idle, which the
// block itself does not enforce; pready is always high. An accepted item
// is held in the input register until the motion stage takes it, and its
// result, if any, is offered on o_out from the output register.
// Throughput: one item per cycle while o_out is not stalled. The input
// stage keeps direction and time stamps, so each item sees the effect of
// the one before it; the motion stage updates velocity and position
// combinationally, bounded by the 16 x 28 bit velocity growth multiplier.
// Reset (synchronous, active low) restores every register to its reset
// value and zeroes position, velocity, direction and time stamps.
// When the receiver stalls, the result waits in the output register; the
// input register still takes one more item, and i_in.ready falls only when
// both are full. Items that produce no result still pass when o_out stalls
// as long as the output register is empty.
module keyboard_cursor_motion #(
    parameter int FRAC_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kcm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [kcm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [kcm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    kcm_stream_if.sink                     i_in,
    kcm_stream_if.source                   o_out
);
    import kcm_pkg::*;

    t_cfg  cfg;
    t_work work;
    logic  work_valid;
    logic  advance;

    // Configuration registers, written by the port and read by both stages.
    kcm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input stage: decodes the item, owns direction and time stamps, and
    // holds the work record until the motion stage takes it.
    kcm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (work_valid),
        .o_work    (work)
    );

    // Motion stage: velocity, position, clamping and the result register.
    kcm_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (work_valid),
        .i_work    (work),
        .o_advance (advance),
        .o_out     (o_out)
    );

endmodule
